FILE: hw/rtl/brs_pkg.sv
`timescale 1ns / 1ps
package brs_pkg;

	localparam int IDX_W  = 17;
	localparam int VAL_W  = 32;
	localparam int CFG_W  = 17;
	localparam int BSZ_W  = 9;
	localparam int ACC_W  = 64;
	localparam int ACT_W  = 2;
	localparam int STS_W  = 2;
	localparam int BASE_W = IDX_W + 1;

	localparam int DEF_MAX_ELEMENTS = 65536;
	localparam int DEF_MAX_BLOCKS   = 256;

	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SUM  = 2'd2;

	localparam logic [0:0] CFG_ELEMENT_COUNT = 1'b0;
	localparam logic [0:0] CFG_BLOCK_SIZE    = 1'b1;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_MOD   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_START,
		S_DIVS,
		S_DIVW,
		S_LDRD,
		S_LDWR,
		S_BLK,
		S_MUL0,
		S_MUL1,
		S_BUPD,
		S_ERD,
		S_EUPD,
		S_MODS,
		S_MODW,
		S_OUT_RNG,
		S_OUT_NEG,
		S_OUT_OK
	} ctrl_state_t;

	typedef struct packed {
		logic    latch;
		logic    clr_start;
		logic    clr_step;
		logic    div_start;
		logic    div_mod;
		logic    div_take;
		logic    ld_wr;
		logic    blk_setup;
		logic    mul0;
		logic    mul1;
		logic    bupd;
		logic    adv;
		logic    i_init;
		logic    eupd;
		logic    emit;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] op;
		logic             ld_ok;
		logic             rng_ok;
		logic             past_end;
		logic             empty;
		logic             full;
		logic             elem_last;
		logic             c_neg;
		logic             div_busy;
		logic             clr_last;
		logic             out_free;
	} sts_t;

endpackage

FILE: hw/rtl/brs_in_if.sv
`timescale 1ns / 1ps
interface brs_in_if;
	import brs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [IDX_W-1:0]        left;
	logic [IDX_W-1:0]        right;
	logic signed [VAL_W-1:0] operand;

	modport source(output valid, output action, output left, output right, output operand,
		input ready);
	modport sink(input valid, input action, input left, input right, input operand,
		output ready);
endinterface

FILE: hw/rtl/brs_out_if.sv
`timescale 1ns / 1ps
interface brs_out_if;
	import brs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] remainder;
	logic [STS_W-1:0]        status;

	modport source(output valid, output remainder, output status, input ready);
	modport sink(input valid, input remainder, input status, output ready);
endinterface

FILE: hw/rtl/brs_ram.sv
`timescale 1ns / 1ps
module brs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/brs_div.sv
`timescale 1ns / 1ps
module brs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [63:0] quotient,
	output logic [31:0] remainder
);
	localparam logic [6:0] STEPS = 7'd64;

	logic [6:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, dvd_q[63]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign busy  = cnt_q != 7'd0;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= 32'd0;
			dsr_q <= divisor;
		end else if (busy) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
		end
	end
endmodule

FILE: hw/rtl/brs_datapath.sv
`timescale 1ns / 1ps
module brs_datapath #(
	parameter int MAX_ELEMENTS = brs_pkg::DEF_MAX_ELEMENTS,
	parameter int MAX_BLOCKS   = brs_pkg::DEF_MAX_BLOCKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [brs_pkg::CFG_W-1:0]       cfg_data,
	input  logic [brs_pkg::ACT_W-1:0]       action,
	input  logic [brs_pkg::IDX_W-1:0]       left,
	input  logic [brs_pkg::IDX_W-1:0]       right,
	input  logic signed [brs_pkg::VAL_W-1:0] operand,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [brs_pkg::VAL_W-1:0] remainder,
	output logic [brs_pkg::STS_W-1:0]       status,
	input  brs_pkg::cmd_t                   cmd,
	output brs_pkg::sts_t                   sts
);
	import brs_pkg::*;

	localparam int EAW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int BW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CLR_LEN = (MAX_ELEMENTS > MAX_BLOCKS) ? MAX_ELEMENTS : MAX_BLOCKS;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int MUL_W   = BASE_W + 32;

	logic [CFG_W-1:0]  ec_q;
	logic [BSZ_W-1:0]  bsz_q;
	logic [CLR_W-1:0]  clr_q;
	logic              out_valid_q;
	logic signed [VAL_W-1:0] rem_out_q;
	logic [STS_W-1:0]  status_q;

	logic [ACT_W-1:0]  op_q;
	logic [IDX_W-1:0]  l_q, r_q, n_q, bs_q, i_q;
	logic [ACC_W-1:0]  c_q, acc_q;
	logic [BW-1:0]     b_q;
	logic [BASE_W-1:0] base_q, from_q, to_q, k_q;
	logic              full_q;
	logic [MUL_W-1:0]  p0_q, p1_q;

	logic [IDX_W-1:0]  n_cur, minbs, bsr, bs_cur;
	logic [BASE_W-1:0] lo, hi_raw, hi, from_c, to_c, n_ext, l_ext, r_ext;
	logic [ACC_W-1:0]  elem_rd, tag_rd, sum_rd, xval, prod, mag;
	logic [31:0]       modulus, rem_pos;
	logic [63:0]       quo;
	logic [31:0]       drem;
	logic              div_busy;
	logic              clr_elem, clr_blk;
	logic              e_we, t_we, s_we;
	logic [EAW-1:0]    e_addr, e_waddr;
	logic [BW-1:0]     b_waddr;
	logic [ACC_W-1:0]  e_wdata, t_wdata, s_wdata;

	assign n_cur  = (32'(ec_q) > 32'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : IDX_W'(ec_q);
	assign minbs  = IDX_W'(32'(n_cur) / MAX_BLOCKS) + IDX_W'(1);
	assign bsr    = (bsz_q == '0) ? IDX_W'(1) : IDX_W'(bsz_q);
	assign bs_cur = (bsr < minbs) ? minbs : bsr;

	assign n_ext  = BASE_W'(n_q);
	assign l_ext  = BASE_W'(l_q);
	assign r_ext  = BASE_W'(r_q);
	assign lo     = (base_q == '0) ? BASE_W'(1) : base_q;
	assign hi_raw = base_q + BASE_W'(bs_q) - BASE_W'(1);
	assign hi     = (hi_raw > n_ext) ? n_ext : hi_raw;
	assign from_c = (l_ext > lo) ? l_ext : lo;
	assign to_c   = (r_ext < hi) ? r_ext : hi;

	assign xval    = (op_q == ACT_ADD) ? c_q : tag_rd;
	assign prod    = ACC_W'(p0_q) + {p1_q[31:0], 32'd0};
	assign mag     = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
	assign modulus = {1'b0, c_q[30:0]} + 32'd1;
	assign rem_pos = drem;

	assign sts.op        = op_q;
	assign sts.ld_ok     = (l_q != '0) && (l_q <= n_q);
	assign sts.rng_ok    = (l_q != '0) && (l_q <= r_q) && (r_q <= n_q);
	assign sts.past_end  = base_q > r_ext;
	assign sts.empty     = from_c > to_c;
	assign sts.full      = full_q;
	assign sts.elem_last = BASE_W'(i_q) == to_q;
	assign sts.c_neg     = c_q[ACC_W-1];
	assign sts.div_busy  = div_busy;
	assign sts.clr_last  = 32'(clr_q) == CLR_LEN - 1;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign remainder = rem_out_q;
	assign status    = status_q;

	assign clr_elem = cmd.clr_step && (32'(clr_q) < MAX_ELEMENTS);
	assign clr_blk  = cmd.clr_step && (32'(clr_q) < MAX_BLOCKS);

	assign e_addr  = EAW'(i_q - IDX_W'(1));
	assign e_we    = clr_elem || cmd.ld_wr || (cmd.eupd && op_q == ACT_ADD);
	assign e_waddr = cmd.clr_step ? EAW'(clr_q) : e_addr;
	assign e_wdata = cmd.clr_step ? '0 : (cmd.ld_wr ? c_q - tag_rd : elem_rd + c_q);

	assign b_waddr = cmd.clr_step ? BW'(clr_q) : b_q;
	assign t_we    = clr_blk || (cmd.bupd && full_q && op_q == ACT_ADD);
	assign t_wdata = cmd.clr_step ? '0 : tag_rd + c_q;
	assign s_we    = clr_blk || cmd.ld_wr || (cmd.bupd && op_q == ACT_ADD);
	assign s_wdata = cmd.clr_step ? '0 :
		(cmd.ld_wr ? sum_rd + c_q - (elem_rd + tag_rd) : sum_rd + prod);

	brs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ELEMENTS), .AW(EAW)) u_elem (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_addr), .rdata(elem_rd));

	brs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_BLOCKS), .AW(BW)) u_tag (
		.clk(clk), .we(t_we), .waddr(b_waddr), .wdata(t_wdata),
		.raddr(b_q), .rdata(tag_rd));

	brs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_BLOCKS), .AW(BW)) u_sum (
		.clk(clk), .we(s_we), .waddr(b_waddr), .wdata(s_wdata),
		.raddr(b_q), .rdata(sum_rd));

	brs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(cmd.div_mod ? mag : 64'(l_q)),
		.divisor(cmd.div_mod ? modulus : 32'(bs_q)),
		.busy(div_busy), .quotient(quo), .remainder(drem));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q        <= CFG_W'(1);
			bsz_q       <= BSZ_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ELEMENT_COUNT: ec_q  <= cfg_data;
					CFG_BLOCK_SIZE:    bsz_q <= cfg_data[BSZ_W-1:0];
				endcase
			end
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= action;
			l_q   <= left;
			r_q   <= right;
			i_q   <= left;
			c_q   <= ACC_W'(operand);
			n_q   <= n_cur;
			bs_q  <= bs_cur;
			acc_q <= '0;
		end
		if (cmd.div_take) begin
			b_q    <= BW'(quo);
			base_q <= l_ext - BASE_W'(drem);
		end
		if (cmd.adv) begin
			b_q    <= b_q + BW'(1);
			base_q <= base_q + BASE_W'(bs_q);
		end
		if (cmd.blk_setup) begin
			from_q <= from_c;
			to_q   <= to_c;
			k_q    <= to_c - from_c + BASE_W'(1);
			full_q <= (from_c == lo) && (to_c == hi);
		end
		if (cmd.mul0) begin
			p0_q <= MUL_W'(k_q) * MUL_W'(xval[31:0]);
		end
		if (cmd.mul1) begin
			p1_q <= MUL_W'(k_q) * MUL_W'(xval[63:32]);
		end
		if (cmd.bupd && op_q == ACT_SUM) begin
			acc_q <= acc_q + (full_q ? sum_rd : prod);
		end
		if (cmd.i_init) begin
			i_q <= IDX_W'(from_q);
		end
		if (cmd.eupd) begin
			i_q <= i_q + IDX_W'(1);
			if (op_q == ACT_SUM) begin
				acc_q <= acc_q + elem_rd;
			end
		end
		if (cmd.emit) begin
			status_q  <= cmd.code;
			if (cmd.code == ST_OK) begin
				rem_out_q <= acc_q[ACC_W-1] ? (VAL_W'(0) - rem_pos) : rem_pos;
			end else begin
				rem_out_q <= '0;
			end
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken item");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !cmd.latch && !cmd.ld_wr && !cmd.eupd && !cmd.bupd)
		else $error("array update during clearing sweep");
endmodule

FILE: hw/rtl/brs_ctrl.sv
`timescale 1ns / 1ps
module brs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          in_valid,
	output logic          in_ready,
	input  brs_pkg::sts_t sts,
	output brs_pkg::cmd_t cmd
);
	import brs_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		if (cfg_we) begin
			cmd.clr_start = 1'b1;
			state_d       = S_CLR;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.latch = 1'b1;
						state_d   = S_START;
					end
				end
				S_START: begin
					unique case (sts.op)
						ACT_LOAD: state_d = sts.ld_ok ? S_DIVS : S_IDLE;
						ACT_ADD:  state_d = sts.rng_ok ? S_DIVS : S_IDLE;
						ACT_SUM:  state_d = sts.rng_ok ? S_DIVS : S_OUT_RNG;
						default:  state_d = S_IDLE;
					endcase
				end
				S_DIVS: begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVW;
				end
				S_DIVW: begin
					if (!sts.div_busy) begin
						cmd.div_take = 1'b1;
						state_d      = (sts.op == ACT_LOAD) ? S_LDRD : S_BLK;
					end
				end
				S_LDRD: state_d = S_LDWR;
				S_LDWR: begin
					cmd.ld_wr = 1'b1;
					state_d   = S_IDLE;
				end
				S_BLK: begin
					priority if (sts.past_end) begin
						if (sts.op == ACT_ADD) state_d = S_IDLE;
						else if (sts.c_neg)    state_d = S_OUT_NEG;
						else                   state_d = S_MODS;
					end else if (sts.empty) begin
						cmd.adv = 1'b1;
					end else begin
						cmd.blk_setup = 1'b1;
						state_d       = S_MUL0;
					end
				end
				S_MUL0: begin
					cmd.mul0 = 1'b1;
					state_d  = S_MUL1;
				end
				S_MUL1: begin
					cmd.mul1 = 1'b1;
					state_d  = S_BUPD;
				end
				S_BUPD: begin
					cmd.bupd = 1'b1;
					if (sts.full) begin
						cmd.adv = 1'b1;
						state_d = S_BLK;
					end else begin
						cmd.i_init = 1'b1;
						state_d    = S_ERD;
					end
				end
				S_ERD: state_d = S_EUPD;
				S_EUPD: begin
					cmd.eupd = 1'b1;
					if (sts.elem_last) begin
						cmd.adv = 1'b1;
						state_d = S_BLK;
					end else begin
						state_d = S_ERD;
					end
				end
				S_MODS: begin
					cmd.div_start = 1'b1;
					cmd.div_mod   = 1'b1;
					state_d       = S_MODW;
				end
				S_MODW: begin
					if (!sts.div_busy) state_d = S_OUT_OK;
				end
				S_OUT_RNG, S_OUT_NEG, S_OUT_OK: begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						unique case (state_q)
							S_OUT_RNG: cmd.code = ST_RANGE;
							S_OUT_NEG: cmd.code = ST_MOD;
							default:   cmd.code = ST_OK;
						endcase
						state_d = S_IDLE;
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/block_range_add_range_sum_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// req       in   valid/ready      action, left, right, operand
// rsp       out  valid/ready      remainder, status
// cfg       in   cfg_we           cfg_index, cfg_data
//
// After reset and after every configuration write the array is cleared by a sweep over
// max(MAX_ELEMENTS, MAX_BLOCKS) addresses, during which no item is accepted.
// A load uses the 64-step serial divider to find the block.
// A range add then walks the blocks, updating a full block's tag and sum, or a partial block's sum and elements.
// A range sum takes the same walk and, unless the operand is negative, divides again for the final remainder.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken in.
module block_range_add_range_sum_top #(
	parameter int MAX_ELEMENTS = brs_pkg::DEF_MAX_ELEMENTS,
	parameter int MAX_BLOCKS   = brs_pkg::DEF_MAX_BLOCKS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [brs_pkg::CFG_W-1:0] cfg_data,
	brs_in_if.sink                    req,
	brs_out_if.source                 rsp
);
	import brs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	brs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.in_valid(req.valid), .in_ready(req.ready),
		.sts(sts), .cmd(cmd));

	brs_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(req.action), .left(req.left), .right(req.right), .operand(req.operand),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.remainder(rsp.remainder), .status(rsp.status),
		.cmd(cmd), .sts(sts));
endmodule
